[hdl/lzsd_pkg.sv]
// Shared types and constants of the LZSS stream decoder.
package lzsd_pkg;

    localparam int unsigned WIN_DEPTH = 4096;
    localparam int unsigned WIN_AW    = 12;
    localparam int unsigned FILL_W    = WIN_AW + 1;

    localparam logic [WIN_AW-1:0] START_POS = 12'hFEE;
    localparam logic [4:0]        MIN_MATCH = 5'd3;

    typedef enum logic [1:0] {
        PH_FLAG   = 2'd0,
        PH_TOKEN  = 2'd1,
        PH_MATCH2 = 2'd2
    } phase_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_COPY = 1'b1
    } state_t;

endpackage

[hdl/lzsd_in_if.sv]
// Input channel of the decoder: one compressed byte per item.
interface lzsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_start;

    modport source (output valid, output in_byte, output stream_start, input ready);
    modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

[hdl/lzsd_out_if.sv]
// Output channel of the decoder: one decoded byte per item.
interface lzsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;

    modport source (output valid, output out_byte, output last_of_run, output stream_done,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input stream_done,
                    output ready);
endinterface

[hdl/lzsd_ram.sv]
// Generic simple dual-port RAM with one registered read port.
module lzsd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/lzss_stream_decoder_core.sv]
// Top level of the LZSS stream decoder with a 4096-byte history window.
// Usage: the decoder takes one compressed byte per input item and returns every decoded byte
// as an output item. A flag byte, a literal byte or the first byte of a match token is handled
// as it is taken. The second byte of a match token issues the first window read; the copy then
// emits one byte per cycle (3 to 18 bytes) while the output register is free and stalls while
// it is not; the single read port of the window memory sets that pace. Input is held off while
// a copy runs or while the output register holds an item that has not been taken. The window
// needs no clearing pass: a fill count tracks how much of it the current stream has written,
// and a read of a position outside that range returns zero. cfg_we writes len_reg at once.
module lzss_stream_decoder_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_wdata,
    lzsd_in_if.sink         in_chan,
    lzsd_out_if.source      out_chan
);

    localparam int unsigned AW = lzsd_pkg::WIN_AW;
    localparam int unsigned FW = lzsd_pkg::FILL_W;

    lzsd_pkg::state_t state_reg, state_next;
    lzsd_pkg::phase_t phase_reg, phase_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [8:0]       flag_reg, flag_next;
    logic [7:0]       low_reg, low_next;
    logic [31:0]      cnt_reg, cnt_next;
    logic             fin_reg, fin_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [31:0]      len_reg;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [4:0]       rem_reg, rem_next;
    logic             ok_reg, ok_next;
    logic             hit_reg, hit_next;
    logic [7:0]       hit_data_reg, hit_data_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             out_done_reg, out_done_next;

    // Effective state after an optional stream restart.
    lzsd_pkg::phase_t e_ph;
    logic [AW-1:0]    e_wp;
    logic [8:0]       e_flag;
    logic [7:0]       e_low;
    logic [31:0]      e_cnt;
    logic             e_fin;
    logic [FW-1:0]    e_fill;

    logic          in_fire;
    logic          slot_free;
    logic          emit;
    logic [7:0]    emit_data;
    logic          end_of_run;
    logic          issue;
    logic [AW-1:0] issue_addr;
    logic [31:0]   cnt_inc;
    logic [AW-1:0] rd_offset;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    lzsd_ram #(
        .WIDTH (8),
        .DEPTH (lzsd_pkg::WIN_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_free        = !out_valid_reg || out_chan.ready;
    assign in_chan.ready    = (state_reg == lzsd_pkg::ST_IDLE) && slot_free;
    assign in_fire          = in_chan.valid && in_chan.ready;
    assign out_chan.valid       = out_valid_reg;
    assign out_chan.out_byte    = out_byte_reg;
    assign out_chan.last_of_run = out_last_reg;
    assign out_chan.stream_done = out_done_reg;

    always_comb
    begin
        if (in_fire && in_chan.stream_start)
        begin
            e_ph   = lzsd_pkg::PH_FLAG;
            e_wp   = lzsd_pkg::START_POS;
            e_flag = '0;
            e_low  = '0;
            e_cnt  = '0;
            e_fin  = 1'b0;
            e_fill = '0;
        end
        else
        begin
            e_ph   = phase_reg;
            e_wp   = wp_reg;
            e_flag = flag_reg;
            e_low  = low_reg;
            e_cnt  = cnt_reg;
            e_fin  = fin_reg;
            e_fill = fill_reg;
        end

        state_next     = state_reg;
        phase_next     = phase_reg;
        wp_next        = wp_reg;
        flag_next      = flag_reg;
        low_next       = low_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        ok_next        = ok_reg;
        hit_next       = hit_reg;
        hit_data_next  = hit_data_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_valid_next = out_chan.ready ? 1'b0 : out_valid_reg;

        emit       = 1'b0;
        emit_data  = in_chan.in_byte;
        end_of_run = 1'b1;
        issue      = 1'b0;
        issue_addr = ptr_reg;
        ram_we     = 1'b0;
        ram_waddr  = e_wp;
        ram_wdata  = emit_data;
        ram_re     = 1'b0;
        ram_raddr  = issue_addr;
        rd_offset  = '0;

        unique case (state_reg)
            lzsd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    phase_next = e_ph;
                    wp_next    = e_wp;
                    flag_next  = e_flag;
                    low_next   = e_low;
                    cnt_next   = e_cnt;
                    fin_next   = e_fin;
                    fill_next  = e_fill;
                    if (!e_fin)
                    begin
                        unique case (e_ph)
                            lzsd_pkg::PH_TOKEN:
                            begin
                                if (e_flag[0])
                                begin
                                    emit       = 1'b1;
                                    emit_data  = in_chan.in_byte;
                                    end_of_run = 1'b1;
                                end
                                else
                                begin
                                    low_next   = in_chan.in_byte;
                                    phase_next = lzsd_pkg::PH_MATCH2;
                                end
                            end
                            lzsd_pkg::PH_MATCH2:
                            begin
                                issue      = 1'b1;
                                issue_addr = {in_chan.in_byte[7:4], e_low};
                                ptr_next   = issue_addr;
                                rem_next   = {1'b0, in_chan.in_byte[3:0]} + lzsd_pkg::MIN_MATCH;
                                state_next = lzsd_pkg::ST_COPY;
                            end
                            default:
                            begin
                                flag_next  = {1'b1, in_chan.in_byte};
                                phase_next = lzsd_pkg::PH_TOKEN;
                            end
                        endcase
                    end
                end
            end
            lzsd_pkg::ST_COPY:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_data  = hit_reg ? hit_data_reg : (ok_reg ? ram_rdata : 8'h00);
                    end_of_run = (rem_reg == 5'd1);
                end
            end
            default:
            begin
                state_next = lzsd_pkg::ST_IDLE;
            end
        endcase

        cnt_inc = e_cnt + 32'd1;
        if (emit)
        begin
            cnt_next       = cnt_inc;
            out_valid_next = 1'b1;
            out_byte_next  = emit_data;
            if (cnt_inc == len_reg)
            begin
                out_last_next = 1'b1;
                out_done_next = 1'b1;
                fin_next      = 1'b1;
                state_next    = lzsd_pkg::ST_IDLE;
            end
            else
            begin
                out_last_next = end_of_run;
                out_done_next = 1'b0;
                ram_we        = 1'b1;
                ram_wdata     = emit_data;
                wp_next       = e_wp + AW'(1);
                if (e_fill != FW'(lzsd_pkg::WIN_DEPTH))
                begin
                    fill_next = e_fill + FW'(1);
                end
                if (end_of_run)
                begin
                    // The token is complete: step to the next flag bit.
                    flag_next  = e_flag >> 1;
                    phase_next = ((e_flag >> 2) == 9'd0) ? lzsd_pkg::PH_FLAG
                                                         : lzsd_pkg::PH_TOKEN;
                    state_next = lzsd_pkg::ST_IDLE;
                end
                else
                begin
                    issue      = 1'b1;
                    issue_addr = ptr_reg + AW'(1);
                    ptr_next   = issue_addr;
                    rem_next   = rem_reg - 5'd1;
                end
            end
        end

        // A read issued in the same cycle as a write to the same position takes the
        // written byte; a position the current stream has not written reads as zero.
        if (issue)
        begin
            ram_re        = 1'b1;
            ram_raddr     = issue_addr;
            rd_offset     = issue_addr - lzsd_pkg::START_POS;
            ok_next       = ({1'b0, rd_offset} < fill_next);
            hit_next      = ram_we && (ram_waddr == issue_addr);
            hit_data_next = ram_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzsd_pkg::ST_IDLE;
            phase_reg     <= lzsd_pkg::PH_FLAG;
            wp_reg        <= lzsd_pkg::START_POS;
            flag_reg      <= '0;
            low_reg       <= '0;
            cnt_reg       <= '0;
            fin_reg       <= 1'b0;
            fill_reg      <= '0;
            len_reg       <= '0;
            ptr_reg       <= '0;
            rem_reg       <= '0;
            ok_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            flag_reg      <= flag_next;
            low_reg       <= low_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            rem_reg       <= rem_next;
            ok_reg        <= ok_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_data_reg <= hit_data_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

endmodule
